[src/sssp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_pkg: shared types and constants of the shortest path block
// Defaults for the parameters, command codes and controller states.
// ----------------------------------------------------------------------------
package sssp_pkg;
	localparam int MAX_VERTICES  = 64;
	localparam int MAX_EDGES     = 256;
	localparam int WEIGHT_BITS   = 16;
	localparam int DISTANCE_BITS = 24;
	localparam int VCOUNT_BITS   = 7;
	localparam int VCOUNT_RESET  = 64;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_RUN = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN_RD,
		ST_SCAN,
		ST_PICK,
		ST_HEAD,
		ST_EDGE_RD,
		ST_EDGE,
		ST_RELAX,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;
endpackage

[src/single_source_shortest_path.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_source_shortest_path: Dijkstra distances over a loaded edge table
// Edges are chained per source vertex in an edge memory; tentative distances
// and settled marks live in a vertex memory. A linear scan picks the next
// vertex to settle.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start for one cycle while busy is low. command 0 adds the edge
//   (edge_source, edge_destination, edge_weight); busy stays low, so edges
//   can be loaded back to back. command 1 runs from start_vertex and
//   raises busy for the reset of the whole vertex memory, then per settled
//   vertex a scan that reads and compares each entry in use plus a pick
//   step, a chain head read for a vertex with outgoing edges and, per
//   chained edge, a read-modify-write of the target distance; a final scan
//   finds nothing. A start vertex out of range skips the search. Then one
//   result per vertex in use, vertex_index in order, each marked by
//   result_valid for one cycle; last_result flags the final one.
//   The receiver cannot stall; results are taken when shown.
//   vertex_count is written through cfg_we / cfg_data only while idle; the
//   block itself does not enforce this, the user must keep to it.
//   Reset empties all edge chains and clears the overflow flag; the edge
//   memory itself is never cleared (chain heads carry valid bits).
// ----------------------------------------------------------------------------
module single_source_shortest_path #(
	parameter int MAX_VERTICES  = sssp_pkg::MAX_VERTICES,
	parameter int MAX_EDGES     = sssp_pkg::MAX_EDGES,
	parameter int WEIGHT_BITS   = sssp_pkg::WEIGHT_BITS,
	parameter int DISTANCE_BITS = sssp_pkg::DISTANCE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic command,
	input  logic [$clog2(MAX_VERTICES)-1:0] edge_source,
	input  logic [$clog2(MAX_VERTICES)-1:0] edge_destination,
	input  logic [WEIGHT_BITS-1:0] edge_weight,
	input  logic [$clog2(MAX_VERTICES)-1:0] start_vertex,
	input  logic cfg_we,
	input  logic [sssp_pkg::VCOUNT_BITS-1:0] cfg_data,
	output logic result_valid,
	output logic [$clog2(MAX_VERTICES)-1:0] vertex_index,
	output logic [DISTANCE_BITS-1:0] path_distance,
	output logic reachable,
	output logic last_result,
	output logic edge_overflow
);
	localparam int VB = $clog2(MAX_VERTICES);
	localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int LB = $clog2(MAX_EDGES + 1);
	localparam int NB = $clog2(MAX_VERTICES + 1);
	localparam int DB = DISTANCE_BITS;
	localparam int VCOUNT_BITS_L = sssp_pkg::VCOUNT_BITS;
	localparam logic [DB-1:0] INF = {DB{1'b1}};
	localparam logic [DB-1:0] SAT = INF - DB'(1);
	localparam logic [LB-1:0] NULL_LINK = LB'(MAX_EDGES);

	// edge memory: target, cost, next link
	logic [VB-1:0]          etgt_mem [MAX_EDGES];
	logic [WEIGHT_BITS-1:0] ecost_mem [MAX_EDGES];
	logic [LB-1:0]          enext_mem [MAX_EDGES];
	// vertex memory: settled mark and tentative distance
	logic [DB:0]            vert_mem [MAX_VERTICES];

	// chain head memory, valid bits give the null reset
	logic [LB-1:0]           head_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] head_vld_q;

	sssp_pkg::state_t state_q, state_d;
	logic [VCOUNT_BITS_L-1:0] vcount_q;
	logic [LB-1:0] stored_q;
	logic          ovf_q;
	logic [NB-1:0] n_act;
	logic [VB-1:0] idx_q;
	logic [VB-1:0] best_q;
	logic [DB-1:0] best_d_q;
	logic          best_found_q;
	logic [LB-1:0] link_q;
	logic [LB-1:0] hops_q;
	logic [VB-1:0] dst_q;
	logic [DB-1:0] nd_q;
	logic          start_ok_q;
	logic          add_pend_q;
	logic [EB-1:0] add_slot_q;
	logic          add_vld_q;

	logic [VB-1:0]          rd_tgt;
	logic [WEIGHT_BITS-1:0] rd_cost;
	logic [LB-1:0]          rd_next;
	logic [LB-1:0]          rd_head;
	logic [VB-1:0]          head_rd_addr;
	logic [DB:0]            rd_vert;
	logic [VB-1:0]          vrd_addr;
	logic                   vwe;
	logic [VB-1:0]          vwr_addr;
	logic [DB:0]            vwr_data;
	logic                   accept;
	logic                   add_ok;
	logic [DB:0]            sum;
	logic                   idx_last;

	assign accept = start && !busy;
	assign busy   = (state_q != sssp_pkg::ST_IDLE);

	// effective vertex count: zero acts as one, clipped to the table
	always_comb begin
		if (vcount_q == '0)
			n_act = NB'(1);
		else if (32'(vcount_q) > MAX_VERTICES)
			n_act = NB'(MAX_VERTICES);
		else
			n_act = NB'(vcount_q);
	end
	assign idx_last = ({1'b0, idx_q} == n_act - NB'(1));

	assign add_ok = accept && (command == sssp_pkg::CMD_ADD)
		&& (32'(edge_source) < MAX_VERTICES)
		&& (32'(edge_destination) < MAX_VERTICES);

	// configuration, edge loading and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= VCOUNT_BITS_L'(sssp_pkg::VCOUNT_RESET);
			stored_q   <= '0;
			ovf_q      <= 1'b0;
			head_vld_q <= '0;
			add_pend_q <= 1'b0;
		end else begin
			if (cfg_we)
				vcount_q <= cfg_data;
			add_pend_q <= add_ok && (stored_q != NULL_LINK);
			if (add_ok) begin
				if (stored_q == NULL_LINK)
					ovf_q <= 1'b1;
				else begin
					stored_q <= stored_q + LB'(1);
					head_vld_q[edge_source] <= 1'b1;
				end
			end
		end
	end

	// chain head read: source vertex while loading, settled vertex in a run
	assign head_rd_addr = busy ? best_q : edge_source;

	always_ff @(posedge clk) begin
		if (add_ok && stored_q != NULL_LINK) begin
			etgt_mem[stored_q[EB-1:0]]  <= edge_destination;
			ecost_mem[stored_q[EB-1:0]] <= edge_weight;
			head_mem[edge_source]       <= stored_q;
		end
		// the new edge is linked to the old head in the next cycle
		if (add_pend_q)
			enext_mem[add_slot_q] <= add_vld_q ? rd_head : NULL_LINK;
		add_slot_q <= stored_q[EB-1:0];
		add_vld_q  <= head_vld_q[edge_source];
		rd_head    <= head_mem[head_rd_addr];
	end

	// edge memory read port
	always_ff @(posedge clk) begin
		rd_tgt  <= etgt_mem[link_q[EB-1:0]];
		rd_cost <= ecost_mem[link_q[EB-1:0]];
		rd_next <= enext_mem[link_q[EB-1:0]];
	end

	// vertex memory: one write, one registered read
	always_comb begin
		vrd_addr = idx_q;
		if (state_q == sssp_pkg::ST_EDGE)
			vrd_addr = rd_tgt;
	end
	always_ff @(posedge clk) begin
		if (vwe)
			vert_mem[vwr_addr] <= vwr_data;
		rd_vert <= vert_mem[vrd_addr];
	end

	assign sum = {1'b0, best_d_q} + (DB+1)'(rd_cost);

	always_comb begin
		vwe      = 1'b0;
		vwr_addr = idx_q;
		vwr_data = {1'b0, INF};
		case (state_q)
			sssp_pkg::ST_INIT: begin
				vwe      = 1'b1;
				vwr_data = {1'b0, (start_ok_q && idx_q == best_q) ? DB'(0) : INF};
			end
			sssp_pkg::ST_PICK: begin
				vwe      = best_found_q;
				vwr_addr = best_q;
				vwr_data = {1'b1, best_d_q};
			end
			sssp_pkg::ST_RELAX: begin
				vwe      = (32'(dst_q) < 32'(n_act)) && !rd_vert[DB] && (nd_q < rd_vert[DB-1:0]);
				vwr_addr = dst_q;
				vwr_data = {1'b0, nd_q};
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sssp_pkg::ST_IDLE:
				if (accept && command == sssp_pkg::CMD_RUN) state_d = sssp_pkg::ST_INIT;
			sssp_pkg::ST_INIT:
				if (32'(idx_q) == MAX_VERTICES - 1)
					state_d = start_ok_q ? sssp_pkg::ST_SCAN_RD : sssp_pkg::ST_EMIT_RD;
			sssp_pkg::ST_SCAN_RD: state_d = sssp_pkg::ST_SCAN;
			sssp_pkg::ST_SCAN:
				if (idx_last) state_d = sssp_pkg::ST_PICK;
				else state_d = sssp_pkg::ST_SCAN_RD;
			sssp_pkg::ST_PICK:
				if (!best_found_q) state_d = sssp_pkg::ST_EMIT_RD;
				else if (head_vld_q[best_q]) state_d = sssp_pkg::ST_HEAD;
				else state_d = sssp_pkg::ST_SCAN_RD;
			sssp_pkg::ST_HEAD:    state_d = sssp_pkg::ST_EDGE_RD;
			sssp_pkg::ST_EDGE_RD: state_d = sssp_pkg::ST_EDGE;
			sssp_pkg::ST_EDGE:    state_d = sssp_pkg::ST_RELAX;
			sssp_pkg::ST_RELAX:
				if (hops_q + LB'(1) < stored_q && link_q < stored_q)
					state_d = sssp_pkg::ST_EDGE_RD;
				else state_d = sssp_pkg::ST_SCAN_RD;
			sssp_pkg::ST_EMIT_RD: state_d = sssp_pkg::ST_EMIT;
			sssp_pkg::ST_EMIT:
				if (idx_last) state_d = sssp_pkg::ST_IDLE;
				else state_d = sssp_pkg::ST_EMIT_RD;
			default: state_d = sssp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sssp_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			sssp_pkg::ST_IDLE: begin
				idx_q      <= '0;
				best_q     <= start_vertex;
				start_ok_q <= ({1'b0, start_vertex} < n_act);
			end
			sssp_pkg::ST_INIT: begin
				idx_q        <= idx_q + VB'(1);
				best_found_q <= 1'b0;
				best_d_q     <= INF;
			end
			sssp_pkg::ST_SCAN: begin
				if (!rd_vert[DB] && rd_vert[DB-1:0] < best_d_q) begin
					best_d_q     <= rd_vert[DB-1:0];
					best_q       <= idx_q;
					best_found_q <= 1'b1;
				end
				idx_q <= idx_last ? '0 : idx_q + VB'(1);
			end
			sssp_pkg::ST_PICK: begin
				hops_q <= '0;
				idx_q  <= '0;
			end
			sssp_pkg::ST_HEAD: link_q <= rd_head;
			sssp_pkg::ST_EDGE: begin
				dst_q  <= rd_tgt;
				nd_q   <= (sum >= {1'b0, INF}) ? SAT : sum[DB-1:0];
				link_q <= rd_next;
			end
			sssp_pkg::ST_RELAX: begin
				hops_q <= hops_q + LB'(1);
				if (state_d == sssp_pkg::ST_SCAN_RD) begin
					best_found_q <= 1'b0;
					best_d_q     <= INF;
				end
			end
			sssp_pkg::ST_EMIT: idx_q <= idx_q + VB'(1);
			default: begin
			end
		endcase
		if (state_q == sssp_pkg::ST_PICK && best_found_q && !head_vld_q[best_q]) begin
			best_found_q <= 1'b0;
			best_d_q     <= INF;
		end
		if (state_q == sssp_pkg::ST_INIT && !start_ok_q)
			idx_q <= (32'(idx_q) == MAX_VERTICES - 1) ? '0 : idx_q + VB'(1);
		if (state_q == sssp_pkg::ST_INIT && 32'(idx_q) == MAX_VERTICES - 1)
			idx_q <= '0;
	end

	// result outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else         result_valid <= (state_q == sssp_pkg::ST_EMIT);
	end
	always_ff @(posedge clk) begin
		vertex_index  <= idx_q;
		path_distance <= rd_vert[DB-1:0];
		reachable     <= (rd_vert[DB-1:0] != INF);
		last_result   <= idx_last;
		edge_overflow <= ovf_q;
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !add_ok) else $error("edge added while busy");
	a_result_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == sssp_pkg::ST_EMIT))
		else $error("stray result");
	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= NULL_LINK) else $error("edge count beyond table");
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_result) |-> !busy) else $error("busy after last");
endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the single source shortest path block
// Loads edges and issues runs through the command port, with random gaps
// between items, and rewrites vertex_count between phases. A scoreboard
// keeps its own copy of the edge chains and predicts every run's distance
// list, which is checked, all fields together, as each result strobes out.
// ----------------------------------------------------------------------------
module tb;
	typedef struct packed {
		bit [5:0]  idx;
		bit [23:0] dist_val;
		bit        reach;
		bit        last;
		bit        ovf;
	} dist_result_t;

	localparam bit [23:0] DIST_NONE = 24'hFFFFFF;
	localparam int        NO_LINK   = sssp_pkg::MAX_EDGES;

	// Scoreboard: edge chain copy, distance predictor, expected result store
	class sssp_scoreboard;
		bit [5:0]     edge_dst[sssp_pkg::MAX_EDGES];
		bit [15:0]    edge_w[sssp_pkg::MAX_EDGES];
		int           edge_link[sssp_pkg::MAX_EDGES];
		int           chain_first[sssp_pkg::MAX_VERTICES];
		int           stored;
		bit           dropped;
		bit [6:0]     vcount;
		dist_result_t pending[$];
		int           errors;

		function new();
			foreach (chain_first[i]) chain_first[i] = NO_LINK;
			stored = 0;
			dropped = 0;
			vcount = 7'(sssp_pkg::VCOUNT_RESET);
			errors = 0;
		endfunction

		// Accepted item: add to chains, or compute all distances
		function void note_item(bit cmd, bit [5:0] src, bit [5:0] dst, bit [15:0] w,
				bit [5:0] from);
			bit [23:0]    dist_v[sssp_pkg::MAX_VERTICES];
			bit           done[sssp_pkg::MAX_VERTICES];
			bit [23:0]    best_d;
			bit [24:0]    sum;
			int           n, best, link, hops;
			dist_result_t r;
			if (cmd == sssp_pkg::CMD_ADD) begin
				if (stored >= sssp_pkg::MAX_EDGES) begin
					dropped = 1;
				end else begin
					edge_dst[stored] = dst;
					edge_w[stored] = w;
					edge_link[stored] = chain_first[src];
					chain_first[src] = stored;
					stored++;
				end
				return;
			end
			n = (vcount == 0) ? 1 : (vcount > sssp_pkg::MAX_VERTICES) ?
				sssp_pkg::MAX_VERTICES : vcount;
			foreach (dist_v[i]) begin
				dist_v[i] = DIST_NONE;
				done[i] = 0;
			end
			if (from < n) begin
				dist_v[from] = 0;
				forever begin
					best = n;
					best_d = DIST_NONE;
					for (int i = 0; i < n; i++)
						if (!done[i] && dist_v[i] < best_d) begin
							best_d = dist_v[i];
							best = i;
						end
					if (best >= n) break;
					done[best] = 1;
					link = chain_first[best];
					for (hops = 0; hops < stored && link < stored; hops++) begin
						sum = best_d + edge_w[link];
						// saturate so all ones stays reserved for unreachable
						if (sum >= DIST_NONE) sum = DIST_NONE - 1;
						if (edge_dst[link] < n && sum[23:0] < dist_v[edge_dst[link]])
							dist_v[edge_dst[link]] = sum[23:0];
						link = edge_link[link];
					end
				end
			end
			for (int i = 0; i < n; i++) begin
				r.idx = 6'(i);
				r.dist_val = dist_v[i];
				r.reach = dist_v[i] != DIST_NONE;
				r.last = (i == n - 1);
				r.ovf = dropped;
				pending = {pending, r};
			end
		endfunction

		function void check_result(dist_result_t got);
			dist_result_t exp_r;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %p, got %p", exp_r, got);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic        command = 0;
	logic [5:0]  edge_source = 0;
	logic [5:0]  edge_destination = 0;
	logic [15:0] edge_weight = 0;
	logic [5:0]  start_vertex = 0;
	logic        cfg_we = 0;
	logic [6:0]  cfg_data = 0;
	logic        result_valid;
	logic [5:0]  vertex_index;
	logic [23:0] path_distance;
	logic        reachable;
	logic        last_result;
	logic        edge_overflow;

	sssp_scoreboard sb = new();
	int gap_pct;
	int cur_n;

	single_source_shortest_path dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.edge_source(edge_source), .edge_destination(edge_destination),
		.edge_weight(edge_weight), .start_vertex(start_vertex),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .result_valid(result_valid),
		.vertex_index(vertex_index), .path_distance(path_distance),
		.reachable(reachable), .last_result(last_result), .edge_overflow(edge_overflow)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Monitor: note accepted items, check strobed results
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_item(command, edge_source, edge_destination, edge_weight,
					start_vertex);
			if (result_valid)
				sb.check_result({vertex_index, path_distance, reachable, last_result,
					edge_overflow});
		end
	end

	// Present one item, hold until taken, then maybe leave a gap
	task automatic send_item(bit cmd, bit [5:0] src, bit [5:0] dst, bit [15:0] w,
			bit [5:0] from);
		start <= 1;
		command <= cmd;
		edge_source <= src;
		edge_destination <= dst;
		edge_weight <= w;
		start_vertex <= from;
		do @(posedge clk); while (busy);
		if ($urandom_range(99) < gap_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic quiesce();
		start <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_vcount(bit [6:0] v);
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		sb.vcount = v;
		cfg_we <= 0;
	endtask

	// Vertex picked mostly inside the graph in use
	function automatic bit [5:0] pick_vertex();
		if ($urandom_range(99) < 85) return 6'($urandom_range(cur_n - 1));
		return 6'($urandom_range(63));
	endfunction

	task automatic random_item();
		bit [15:0] w;
		case ($urandom_range(3))
			0: w = 0;
			1: w = 16'hFFFF;
			default: w = 16'($urandom_range(16'hFFFF));
		endcase
		if ($urandom_range(99) < 88)
			send_item(sssp_pkg::CMD_ADD, pick_vertex(), pick_vertex(), w,
				6'($urandom_range(63)));
		else
			send_item(sssp_pkg::CMD_RUN, 6'($urandom_range(63)), 6'($urandom_range(63)),
				16'($urandom_range(16'hFFFF)), pick_vertex());
	endtask

	initial begin
		int vc_list[8] = '{6, 1, 0, 127, 3, 9, 64, 17};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: small graph with parallel edges, self loop, unused vertices
		gap_pct = 17;
		write_vcount(6);
		send_item(sssp_pkg::CMD_ADD, 0, 1, 16'd0, 0);
		send_item(sssp_pkg::CMD_ADD, 1, 2, 16'hFFFF, 0);
		send_item(sssp_pkg::CMD_ADD, 0, 2, 16'd5, 0);
		send_item(sssp_pkg::CMD_ADD, 2, 3, 16'd7, 0);
		send_item(sssp_pkg::CMD_ADD, 3, 0, 16'd1, 0);
		send_item(sssp_pkg::CMD_ADD, 0, 1, 16'd3, 0);
		send_item(sssp_pkg::CMD_ADD, 5, 63, 16'd2, 0);
		send_item(sssp_pkg::CMD_ADD, 63, 4, 16'd2, 0);
		send_item(sssp_pkg::CMD_ADD, 4, 4, 16'd9, 0);
		send_item(sssp_pkg::CMD_RUN, 0, 0, 0, 0);
		send_item(sssp_pkg::CMD_RUN, 63, 63, 16'hFFFF, 63);
		send_item(sssp_pkg::CMD_RUN, 0, 0, 0, 5);
		send_item(sssp_pkg::CMD_ADD, 63, 63, 16'hFFFF, 63);
		send_item(sssp_pkg::CMD_RUN, 0, 0, 0, 2);
		quiesce();

		// Random phases: new vertex count each, idling pattern per third
		for (int p = 0; p < 8; p++) begin
			gap_pct = (p < 3) ? 17 : (p < 6) ? 80 : 0;
			write_vcount(7'(vc_list[p]));
			cur_n = (vc_list[p] == 0) ? 1 : (vc_list[p] > 64) ? 64 : vc_list[p];
			for (int k = 0; k < 30; k++) random_item();
			send_item(sssp_pkg::CMD_RUN, 0, 0, 0, pick_vertex());
			quiesce();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
